// ----- src/jvs_pkg.sv -----
// shared types and constants for the jvs packet deframer
`default_nettype none

package jvs_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RX_ENABLE         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NODE_ADDRESS      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BROADCAST_ADDRESS = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_CODE         = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESCAPE_CODE       = 3'd4;

   localparam logic [BYTE_WIDTH-1:0] RST_NODE_ADDRESS      = 8'd0;
   localparam logic [BYTE_WIDTH-1:0] RST_BROADCAST_ADDRESS = 8'd255;
   localparam logic [BYTE_WIDTH-1:0] RST_SYNC_CODE         = 8'd224;
   localparam logic [BYTE_WIDTH-1:0] RST_ESCAPE_CODE       = 8'd208;

   typedef enum logic [2:0] {
      PH_WAIT  = 3'd0,
      PH_NODE  = 3'd1,
      PH_COUNT = 3'd2,
      PH_DATA  = 3'd3,
      PH_SUM   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_GOOD  = 2'd1,
      KIND_BAD   = 2'd2,
      KIND_ABORT = 2'd3
   } kind_type;

   typedef struct packed {
      logic                  rx_enable;
      logic [BYTE_WIDTH-1:0] node_address;
      logic [BYTE_WIDTH-1:0] broadcast_address;
      logic [BYTE_WIDTH-1:0] sync_code;
      logic [BYTE_WIDTH-1:0] escape_code;
   } cfg_type;

   typedef struct packed {
      kind_type              kind;
      logic [BYTE_WIDTH-1:0] byte_value;
      logic [BYTE_WIDTH-1:0] packet_node;
      logic [BYTE_WIDTH-1:0] byte_index;
      logic                  last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/jvs_csr.sv -----
// configuration registers of the deframer
`default_nettype none

module jvs_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [jvs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [jvs_pkg::BYTE_WIDTH-1:0]      csr_write_data,
   output jvs_pkg::cfg_type                         cfg
);

   jvs_pkg::cfg_type cfg_ff;
   jvs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            jvs_pkg::CSR_RX_ENABLE:         cfg_in.rx_enable         = csr_write_data[0];
            jvs_pkg::CSR_NODE_ADDRESS:      cfg_in.node_address      = csr_write_data;
            jvs_pkg::CSR_BROADCAST_ADDRESS: cfg_in.broadcast_address = csr_write_data;
            jvs_pkg::CSR_SYNC_CODE:         cfg_in.sync_code         = csr_write_data;
            jvs_pkg::CSR_ESCAPE_CODE:       cfg_in.escape_code       = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rx_enable         <= 1'b0;
         cfg_ff.node_address      <= jvs_pkg::RST_NODE_ADDRESS;
         cfg_ff.broadcast_address <= jvs_pkg::RST_BROADCAST_ADDRESS;
         cfg_ff.sync_code         <= jvs_pkg::RST_SYNC_CODE;
         cfg_ff.escape_code       <= jvs_pkg::RST_ESCAPE_CODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/jvs_parser.sv -----
// input word register and packet state machine of the deframer
`default_nettype none

module jvs_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  jvs_pkg::cfg_type                    cfg,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [jvs_pkg::BYTE_WIDTH-1:0] req_rx_byte,
   input  wire logic                           out_free,
   output logic                                res_valid,
   output jvs_pkg::rsp_type                    res
);

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic [jvs_pkg::BYTE_WIDTH-1:0] in_byte_ff;

   jvs_pkg::phase_type             phase_ff;
   jvs_pkg::phase_type             phase_in;
   logic                           escape_ff;
   logic                           escape_in;
   logic [jvs_pkg::BYTE_WIDTH-1:0] node_ff;
   logic [jvs_pkg::BYTE_WIDTH-1:0] node_in;
   logic [jvs_pkg::BYTE_WIDTH-1:0] remaining_ff;
   logic [jvs_pkg::BYTE_WIDTH-1:0] remaining_in;
   logic [jvs_pkg::BYTE_WIDTH-1:0] position_ff;
   logic [jvs_pkg::BYTE_WIDTH-1:0] position_in;
   logic [jvs_pkg::BYTE_WIDTH-1:0] sum_ff;
   logic [jvs_pkg::BYTE_WIDTH-1:0] sum_in;

   logic                           advance;
   logic                           work;
   logic                           is_sync;
   logic                           is_escape;
   logic                           in_packet;
   logic                           node_match;
   logic [jvs_pkg::BYTE_WIDTH-1:0] value;

   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign in_valid_in = req_valid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   assign work       = advance && cfg.rx_enable;
   assign is_sync    = in_byte_ff == cfg.sync_code;
   assign is_escape  = in_byte_ff == cfg.escape_code;
   assign value      = escape_ff ? in_byte_ff + 8'd1 : in_byte_ff;
   assign node_match = (value == cfg.node_address) || (value == cfg.broadcast_address);
   assign in_packet  = (phase_ff == jvs_pkg::PH_COUNT) || (phase_ff == jvs_pkg::PH_DATA)
                    || (phase_ff == jvs_pkg::PH_SUM);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (work) begin
         if (is_sync) begin
            phase_in = jvs_pkg::PH_NODE;
         end else if (phase_ff != jvs_pkg::PH_WAIT && !is_escape) begin
            unique case (phase_ff)
               jvs_pkg::PH_NODE: begin
                  phase_in = node_match ? jvs_pkg::PH_COUNT : jvs_pkg::PH_WAIT;
               end
               jvs_pkg::PH_COUNT: begin
                  if (value == 8'd0) begin
                     phase_in = jvs_pkg::PH_WAIT;
                  end else if (value == 8'd1) begin
                     phase_in = jvs_pkg::PH_SUM;
                  end else begin
                     phase_in = jvs_pkg::PH_DATA;
                  end
               end
               jvs_pkg::PH_DATA: begin
                  if (remaining_ff == 8'd1) begin
                     phase_in = jvs_pkg::PH_SUM;
                  end
               end
               default: phase_in = jvs_pkg::PH_WAIT;
            endcase
         end
      end
   end

   // packet registers and result
   always_comb begin
      escape_in        = escape_ff;
      node_in          = node_ff;
      remaining_in     = remaining_ff;
      position_in      = position_ff;
      sum_in           = sum_ff;
      res_valid        = 1'b0;
      res.kind         = jvs_pkg::KIND_DATA;
      res.byte_value   = value;
      res.packet_node  = node_ff;
      res.byte_index   = position_ff;
      res.last         = 1'b0;
      if (work) begin
         if (is_sync) begin
            escape_in = 1'b0;
            if (in_packet) begin
               res_valid      = 1'b1;
               res.kind       = jvs_pkg::KIND_ABORT;
               res.byte_value = '0;
               res.last       = 1'b1;
            end
         end else if (phase_ff != jvs_pkg::PH_WAIT) begin
            if (is_escape) begin
               escape_in = 1'b1;
            end else begin
               escape_in = 1'b0;
               unique case (phase_ff)
                  jvs_pkg::PH_NODE: begin
                     if (node_match) begin
                        node_in = value;
                        sum_in  = value;
                     end
                  end
                  jvs_pkg::PH_COUNT: begin
                     if (value != 8'd0) begin
                        sum_in       = sum_ff + value;
                        position_in  = '0;
                        remaining_in = value - 8'd1;
                     end
                  end
                  jvs_pkg::PH_DATA: begin
                     res_valid    = 1'b1;
                     sum_in       = sum_ff + value;
                     position_in  = position_ff + 8'd1;
                     remaining_in = remaining_ff - 8'd1;
                  end
                  jvs_pkg::PH_SUM: begin
                     res_valid = 1'b1;
                     res.kind  = (value == sum_ff) ? jvs_pkg::KIND_GOOD : jvs_pkg::KIND_BAD;
                     res.last  = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= jvs_pkg::PH_WAIT;
         escape_ff    <= 1'b0;
         node_ff      <= '0;
         remaining_ff <= '0;
         position_ff  <= '0;
         sum_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         escape_ff    <= escape_in;
         node_ff      <= node_in;
         remaining_ff <= remaining_in;
         position_ff  <= position_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

endmodule

`default_nettype wire

// ----- src/jvs_out_reg.sv -----
// result word register of the deframer
`default_nettype none

module jvs_out_reg (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        res_valid,
   input  jvs_pkg::rsp_type res,
   output logic            out_free,
   output logic            rsp_valid,
   input  wire logic        rsp_ready,
   output jvs_pkg::rsp_type rsp
);

   logic             valid_ff;
   logic             valid_in;
   jvs_pkg::rsp_type data_ff;
   logic             load;

   assign out_free = !valid_ff || rsp_ready;
   assign load     = res_valid && out_free;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

`default_nettype wire

// ----- src/jvs_packet_deframer_top.sv -----
// top level of the jvs packet deframer
//
//   channel | direction | handshake             | words
//   req     | in        | req_valid/req_ready   | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_ready   | rsp_kind, rsp_byte_value, rsp_packet_node,
//           |           |                       | rsp_byte_index, rsp_last
//   csr     | in        | csr_write_enable      | csr_index, csr_write_data
//
// one word per cycle while rsp is not stalled; a word is registered, parsed, and any result registered
// a stalled rsp holds one result and one pending input word, then req_ready drops
// synchronous reset clears the packet state and the registers to their defaults
`default_nettype none

module jvs_packet_deframer_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [jvs_pkg::BYTE_WIDTH-1:0]      req_rx_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_kind,
   output logic [jvs_pkg::BYTE_WIDTH-1:0]           rsp_byte_value,
   output logic [jvs_pkg::BYTE_WIDTH-1:0]           rsp_packet_node,
   output logic [jvs_pkg::BYTE_WIDTH-1:0]           rsp_byte_index,
   output logic                                     rsp_last,
   input  wire logic                                csr_write_enable,
   input  wire logic [jvs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [jvs_pkg::BYTE_WIDTH-1:0]      csr_write_data
);

   jvs_pkg::cfg_type cfg;
   jvs_pkg::rsp_type res;
   jvs_pkg::rsp_type rsp;
   logic             res_valid;
   logic             out_free;

   jvs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   jvs_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res)
   );

   jvs_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_kind        = rsp.kind;
   assign rsp_byte_value  = rsp.byte_value;
   assign rsp_packet_node = rsp.packet_node;
   assign rsp_byte_index  = rsp.byte_index;
   assign rsp_last        = rsp.last;

endmodule

`default_nettype wire

// ----- src/jvs_checker.sv -----
// port checks for the jvs packet deframer and their binding
`default_nettype none

module jvs_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [1:0]                          rsp_kind,
   input wire logic [jvs_pkg::BYTE_WIDTH-1:0]      rsp_byte_value,
   input wire logic [jvs_pkg::BYTE_WIDTH-1:0]      rsp_packet_node,
   input wire logic [jvs_pkg::BYTE_WIDTH-1:0]      rsp_byte_index,
   input wire logic                                rsp_last
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_byte_value)
         && $stable(rsp_packet_node) && $stable(rsp_byte_index) && $stable(rsp_last))
      else $error("stalled rsp word changed");

   // last marks exactly the closing words
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != jvs_pkg::KIND_DATA)))
      else $error("rsp_last disagrees with rsp_kind");

   // an abort carries no byte
   a_abort_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == jvs_pkg::KIND_ABORT |-> rsp_byte_value == '0)
      else $error("abort word with nonzero byte");

   // two data words in a row of one packet count up by one
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == jvs_pkg::KIND_DATA
         ##1 rsp_valid && rsp_kind == jvs_pkg::KIND_DATA
      |-> rsp_byte_index == $past(rsp_byte_index) + 8'd1)
      else $error("data index did not step by one");

endmodule

bind jvs_packet_deframer_top jvs_checker u_jvs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_byte_value   (rsp_byte_value),
   .rsp_packet_node  (rsp_packet_node),
   .rsp_byte_index   (rsp_byte_index),
   .rsp_last         (rsp_last)
);

`default_nettype wire

// ----- dv/deframer_check_pkg.sv -----
// scoreboard for the jvs packet deframer: byte-level predictor and in-order result check
package deframer_check_pkg;
   import jvs_pkg::*;

   class packet_scoreboard;
      cfg_type               cfg;
      phase_type             phase;
      logic                  escape_armed;
      logic [BYTE_WIDTH-1:0] node_seen;
      logic [BYTE_WIDTH-1:0] remaining;
      logic [BYTE_WIDTH-1:0] position;
      logic [BYTE_WIDTH-1:0] checksum;
      rsp_type               expected_results[$];
      int                    mismatches;
      int                    kind_count[4];

      function new();
         cfg.rx_enable         = 1'b0;
         cfg.node_address      = RST_NODE_ADDRESS;
         cfg.broadcast_address = RST_BROADCAST_ADDRESS;
         cfg.sync_code         = RST_SYNC_CODE;
         cfg.escape_code       = RST_ESCAPE_CODE;
         phase                 = PH_WAIT;
         escape_armed          = 1'b0;
         node_seen             = '0;
         remaining             = '0;
         position              = '0;
         checksum              = '0;
         mismatches            = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [BYTE_WIDTH-1:0] value);
         case (index)
            CSR_RX_ENABLE:         cfg.rx_enable         = value[0];
            CSR_NODE_ADDRESS:      cfg.node_address      = value;
            CSR_BROADCAST_ADDRESS: cfg.broadcast_address = value;
            CSR_SYNC_CODE:         cfg.sync_code         = value;
            CSR_ESCAPE_CODE:       cfg.escape_code       = value;
            default: ;
         endcase
      endfunction

      function void push_result(kind_type kind, logic [BYTE_WIDTH-1:0] value, logic closing);
         rsp_type r;
         r.kind        = kind;
         r.byte_value  = value;
         r.packet_node = node_seen;
         r.byte_index  = position;
         r.last        = closing;
         expected_results.push_back(r);
      endfunction

      // one accepted word in, zero or one expected result out
      function void note_byte(logic [BYTE_WIDTH-1:0] raw);
         logic [BYTE_WIDTH-1:0] b;
         b = raw;
         if (!cfg.rx_enable) return;
         if (b == cfg.sync_code) begin
            if (phase == PH_COUNT || phase == PH_DATA || phase == PH_SUM) begin
               push_result(KIND_ABORT, '0, 1'b1);
            end
            phase        = PH_NODE;
            escape_armed = 1'b0;
            return;
         end
         if (phase == PH_WAIT) return;
         if (b == cfg.escape_code) begin
            escape_armed = 1'b1;
            return;
         end
         if (escape_armed) begin
            b            = b + 8'd1;
            escape_armed = 1'b0;
         end
         case (phase)
            PH_NODE: begin
               if (b == cfg.node_address || b == cfg.broadcast_address) begin
                  node_seen = b;
                  checksum  = b;
                  phase     = PH_COUNT;
               end else begin
                  phase = PH_WAIT;
               end
            end
            PH_COUNT: begin
               if (b == 8'd0) begin
                  phase = PH_WAIT;
               end else begin
                  checksum  = checksum + b;
                  position  = '0;
                  remaining = b - 8'd1;
                  phase     = (remaining != 8'd0) ? PH_DATA : PH_SUM;
               end
            end
            PH_DATA: begin
               push_result(KIND_DATA, b, 1'b0);
               checksum  = checksum + b;
               position  = position + 8'd1;
               remaining = remaining - 8'd1;
               if (remaining == 8'd0) phase = PH_SUM;
            end
            PH_SUM: begin
               push_result((b == checksum) ? KIND_GOOD : KIND_BAD, b, 1'b1);
               phase = PH_WAIT;
            end
            default: phase = PH_WAIT;
         endcase
      endfunction

      function string show(rsp_type r);
         return $sformatf("kind %0d value %02h node %02h index %0d last %0d",
                          r.kind, r.byte_value, r.packet_node, r.byte_index, r.last);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", show(got));
            return;
         end
         want = expected_results.pop_front();
         if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
             got.packet_node !== want.packet_node || got.byte_index !== want.byte_index ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected %s, got %s", show(want), show(got));
            end
         end else begin
            kind_count[int'(want.kind)]++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

endpackage

// ----- dv/testbench.sv -----
// testbench for the jvs packet deframer: directed and random byte streams with a scoreboard
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import jvs_pkg::*;
   import deframer_check_pkg::*;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [BYTE_WIDTH-1:0]      req_rx_byte;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [1:0]                 rsp_kind;
   logic [BYTE_WIDTH-1:0]      rsp_byte_value;
   logic [BYTE_WIDTH-1:0]      rsp_packet_node;
   logic [BYTE_WIDTH-1:0]      rsp_byte_index;
   logic                       rsp_last;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [BYTE_WIDTH-1:0]      csr_write_data;

   packet_scoreboard sb;
   int               bytes_sent;
   int               burst_left;
   int               settings_used;
   bit               hold_request;

   jvs_packet_deframer_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_packet_node  (rsp_packet_node),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   task automatic send_byte(input logic [BYTE_WIDTH-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(value);
      burst_left--;
      bytes_sent++;
   endtask

   // escape reserved values, and now and then an ordinary one, unless the escaped form is reserved
   task automatic send_value(input logic [BYTE_WIDTH-1:0] value);
      logic [BYTE_WIDTH-1:0] shifted;
      shifted = value - 8'd1;
      if ((value == sb.cfg.sync_code || value == sb.cfg.escape_code ||
           $urandom_range(0, 9) == 0) &&
          shifted != sb.cfg.sync_code && shifted != sb.cfg.escape_code) begin
         send_byte(sb.cfg.escape_code);
         send_byte(shifted);
      end else begin
         send_byte(value);
      end
   endtask

   task automatic send_packet(input bit truncate);
      logic [BYTE_WIDTH-1:0] values[$];
      logic [BYTE_WIDTH-1:0] node;
      logic [BYTE_WIDTH-1:0] count;
      logic [BYTE_WIDTH-1:0] data;
      logic [BYTE_WIDTH-1:0] sum;
      int                    pick;
      int                    keep;
      pick = $urandom_range(0, 99);
      if (pick < 60) node = sb.cfg.node_address;
      else if (pick < 85) node = sb.cfg.broadcast_address;
      else node = $urandom_range(0, 255);
      pick = $urandom_range(0, 99);
      if (pick < 5) count = 8'd0;
      else if (pick < 85) count = $urandom_range(1, 8);
      else if (pick < 97) count = $urandom_range(9, 40);
      else count = $urandom_range(200, 255);
      values.push_back(node);
      values.push_back(count);
      sum = node + count;
      for (int i = 1; i < count; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) data = sb.cfg.sync_code;
         else if (pick == 1) data = sb.cfg.escape_code;
         else data = $urandom_range(0, 255);
         values.push_back(data);
         sum = sum + data;
      end
      if ($urandom_range(0, 4) == 0) sum = $urandom_range(0, 255);
      values.push_back(sum);
      keep = truncate ? $urandom_range(1, values.size() - 1) : values.size();
      send_byte(sb.cfg.sync_code);
      for (int i = 0; i < keep; i++) send_value(values[i]);
   endtask

   task automatic run_traffic(input int items);
      int target;
      int pick;
      target = bytes_sent + items;
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            send_packet(1'b0);
         end else if (pick < 90) begin
            send_packet(1'b1);
         end else begin
            repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 255));
         end
      end
   endtask

   task automatic settle();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [BYTE_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      sb.write_reg(index, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic enable, input logic [BYTE_WIDTH-1:0] node,
                                input logic [BYTE_WIDTH-1:0] bcast,
                                input logic [BYTE_WIDTH-1:0] sync,
                                input logic [BYTE_WIDTH-1:0] esc);
      settle();
      write_reg(CSR_NODE_ADDRESS, node);
      write_reg(CSR_BROADCAST_ADDRESS, bcast);
      write_reg(CSR_SYNC_CODE, sync);
      write_reg(CSR_ESCAPE_CODE, esc);
      write_reg(CSR_RX_ENABLE, {7'd0, enable});
      settings_used++;
   endtask

   task automatic send_list(input logic [BYTE_WIDTH-1:0] words[$]);
      foreach (words[i]) send_byte(words[i]);
   endtask

   // result side: check accepted words, stall on a changing pattern
   initial begin
      rsp_type got;
      int      mode_left;
      int      ready_pct;
      int      hold_left;
      rsp_ready = 1'b0;
      mode_left = 0;
      ready_pct = 100;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.kind        = kind_type'(rsp_kind);
            got.byte_value  = rsp_byte_value;
            got.packet_node = rsp_packet_node;
            got.byte_index  = rsp_byte_index;
            got.last        = rsp_last;
            sb.check_result(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 150;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(50, 300);
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 70;
               2: ready_pct = 40;
               default: ready_pct = 10;
            endcase
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_rx_byte      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      hold_request     = 1'b0;
      bytes_sent       = 0;
      burst_left       = 0;
      settings_used    = 0;
      sb               = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // receiver still disabled after reset
      send_list('{RST_SYNC_CODE, 8'h01, 8'h01, 8'h05});

      apply_setting(1'b1, 8'h01, RST_BROADCAST_ADDRESS, RST_SYNC_CODE, RST_ESCAPE_CODE);
      send_list('{8'h5a, RST_ESCAPE_CODE});
      send_list('{RST_SYNC_CODE, 8'h01, 8'h04, RST_ESCAPE_CODE, 8'hdf, 8'hff, 8'h00, 8'he4});
      send_list('{RST_SYNC_CODE, 8'hff, 8'h01, 8'h55});
      send_list('{RST_SYNC_CODE, 8'h01, 8'h00, 8'h33});
      send_list('{RST_SYNC_CODE, 8'h07, 8'h02});
      send_list('{RST_SYNC_CODE, RST_SYNC_CODE, 8'h01, 8'h02, RST_ESCAPE_CODE,
                  RST_ESCAPE_CODE, 8'h05, RST_SYNC_CODE, 8'h01, 8'h01, 8'h02});

      run_traffic(300);
      apply_setting(1'b1, 8'h00, 8'h00, 8'h00, 8'hff);
      run_traffic(200);
      apply_setting(1'b1, 8'hff, 8'hff, 8'hff, 8'h00);
      run_traffic(200);
      apply_setting(1'b1, $urandom_range(0, 255), $urandom_range(0, 255), 8'h5c, 8'h5c);
      run_traffic(150);
      apply_setting(1'b1, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      hold_request = 1'b1;
      run_traffic(300);
      apply_setting(1'b0, 8'h10, RST_BROADCAST_ADDRESS, RST_SYNC_CODE, RST_ESCAPE_CODE);
      run_traffic(50);
      apply_setting(1'b1, 8'h10, $urandom_range(0, 255), RST_SYNC_CODE, RST_ESCAPE_CODE);
      run_traffic(150);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d bytes under %0d register settings, incl. disabled receiver",
               bytes_sent, settings_used);
      $display("results matched: %0d data, %0d good end, %0d bad end, %0d abort",
               sb.kind_count[KIND_DATA], sb.kind_count[KIND_GOOD],
               sb.kind_count[KIND_BAD], sb.kind_count[KIND_ABORT]);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
